// ===== design/htsm_pkg.sv =====
// Package for the heater thermal safety monitor.
// Holds the operation codes, register indexes and the result word layout.
// It depends on nothing else.
package htsm_pkg;

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_MONITOR = 2'd0,
        OP_RISE    = 2'd1,
        OP_START   = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMPERATURE  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_LIMIT       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_THRESHOLD   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_SAMPLES    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW_OFFSET  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_HIGH_OFFSET = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_ENABLE      = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_MODE        = 4'd7;

    localparam int unsigned CFG_DATA_W = 16;

    // Minimum number of samples a rise check gathers.
    localparam logic [7:0] MIN_CHECK_SAMPLES = 8'd4;

    // Successive drops beyond this count trip the long drop flag.
    localparam logic [3:0] LONG_DROP_COUNT = 4'd10;

    // One result word; the last member sits in the lowest bit.
    typedef struct packed {
        logic drive_at_limit;
        logic rise_check_escaped;
        logic long_drop;
        logic sharp_drop;
        logic no_rise;
        logic over_temperature;
    } result_t;

endpackage

// ===== design/heater_thermal_safety_monitor.sv =====
// Heater thermal safety monitor top level.
// Depends on htsm_pkg for operation codes, register indexes and the result layout.
//
// Usage:
// Input words arrive on the s_ channel: s_tuser carries the operation (monitor
// tick, rise-check tick, start, stop) and s_tdata the temperature, setpoint,
// drive and drive limit. Every accepted word yields exactly one result word on
// the m_ channel, carrying the trip flags and the latched drive-at-limit flag.
// The configuration channel writes one register per handshake; it is always
// ready and should only be used while no result is outstanding. Writing
// slow_mode as zero also restarts monitoring.
// The result of a word accepted at an edge is loaded into the output register at
// that same edge. All state updates and trip checks are done in a single pass of
// compares and subtractions, so one word per cycle is sustained while results are
// taken. The output register alone sets the pace: while a result is held and the
// receiver stalls, s_tready is low; a result taken in the same cycle frees the
// register for a new word.
// Reset clears the monitor and rise-check run flags (both stopped), the drop and
// sample counters and the drive flag, and loads the register defaults. The
// last-four sample store has no reset; it is always filled before it is read.
module heater_thermal_safety_monitor
    import htsm_pkg::*;
#(
    parameter int unsigned MAX_CHECK_SAMPLES = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tdata: temperature[15:0], setpoint[31:16], drive[43:32],
    // drive_limit[55:44].
    input  logic [55:0]            s_tdata,
    // tuser: operation[1:0].
    input  logic [1:0]             s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // tdata: over_temperature[0], no_rise[1], sharp_drop[2], long_drop[3],
    // rise_check_escaped[4], drive_at_limit[5], zero padding[7:6].
    output logic [7:0]             m_tdata,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_CHECK_SAMPLES + 1);
    localparam logic [7:0] MAX_SAMPLES_8 = 8'(MAX_CHECK_SAMPLES);

    // Configuration registers.
    logic signed [15:0] max_temperature_reg;
    logic [14:0]        drop_limit_reg;
    logic signed [15:0] rise_threshold_reg;
    logic [7:0]         check_samples_reg;
    logic signed [15:0] band_low_offset_reg;
    logic signed [15:0] band_high_offset_reg;
    logic               band_enable_reg;
    logic               slow_mode_reg;

    // Monitor state.
    logic signed [15:0] prev_temp_reg, prev_temp_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [3:0]         drop_cnt_reg, drop_cnt_next;
    logic               drive_sat_reg, drive_sat_next;
    logic [CNT_W-1:0]   sample_cnt_reg, sample_cnt_next;
    logic signed [15:0] recent_reg [4];
    logic signed [15:0] recent_next [4];
    logic               mon_run_reg, mon_run_next;
    logic               rise_run_reg, rise_run_next;

    // Output register.
    logic               out_valid_reg;
    result_t            out_data_reg, result;

    // Handshakes and unpacked input fields.
    logic               in_accept;
    logic               cfg_accept;
    op_t                op;
    logic signed [15:0] temp;
    logic signed [15:0] setpoint;
    logic signed [11:0] drive;
    logic signed [11:0] drive_limit;

    // Rise-check helpers.
    logic signed [16:0] band_lo;
    logic signed [16:0] band_hi;
    logic               in_band;
    logic [CNT_W-1:0]   n_eff;
    logic signed [16:0] rise_diff;
    logic signed [17:0] rise_limit;
    logic signed [16:0] temp_diff;
    logic [16:0]        drop_mag;
    logic [3:0]         drop_inc;

    assign in_accept  = s_tvalid && s_tready;
    assign s_tready   = !out_valid_reg || m_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign op          = op_t'(s_tuser);
    assign temp        = s_tdata[15:0];
    assign setpoint    = s_tdata[31:16];
    assign drive       = s_tdata[43:32];
    assign drive_limit = s_tdata[55:44];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    // Band edges, clamped sample count and the rise judgement terms.
    assign band_lo    = 17'(setpoint) + 17'(band_low_offset_reg);
    assign band_hi    = 17'(setpoint) + 17'(band_high_offset_reg);
    assign in_band    = band_enable_reg && (17'(temp) > band_lo) && (17'(temp) < band_hi);
    assign rise_diff  = 17'(recent_reg[0]) - 17'(recent_reg[3]);
    assign rise_limit = 18'(rise_threshold_reg) + (18'(rise_threshold_reg) <<< 1);
    assign temp_diff  = prev_valid_reg ? (17'(temp) - 17'(prev_temp_reg)) : 17'sd0;
    assign drop_mag   = 17'(-temp_diff);
    assign drop_inc   = drop_cnt_reg + 4'd1;

    always_comb
    begin
        if (check_samples_reg < MIN_CHECK_SAMPLES)
        begin
            n_eff = CNT_W'(MIN_CHECK_SAMPLES);
        end
        else if (check_samples_reg > MAX_SAMPLES_8)
        begin
            n_eff = CNT_W'(MAX_SAMPLES_8);
        end
        else
        begin
            n_eff = CNT_W'(check_samples_reg);
        end
    end

    // Next state and the result of one accepted word.
    always_comb
    begin
        logic do_step;
        logic sat_used;
        prev_temp_next  = prev_temp_reg;
        prev_valid_next = prev_valid_reg;
        drop_cnt_next   = drop_cnt_reg;
        drive_sat_next  = drive_sat_reg;
        sample_cnt_next = sample_cnt_reg;
        mon_run_next    = mon_run_reg;
        rise_run_next   = rise_run_reg;
        for (int i = 0; i < 4; i++)
        begin
            recent_next[i] = recent_reg[i];
        end
        result   = '0;
        do_step  = 1'b0;
        sat_used = drive_sat_reg;

        if (in_accept)
        begin
            // Decide whether a rise-check step runs on this word.
            unique case (op)
                OP_RISE:
                begin
                    do_step = rise_run_reg && !slow_mode_reg;
                end
                OP_MONITOR:
                begin
                    if (mon_run_reg && !slow_mode_reg)
                    begin
                        drive_sat_next = (drive >= drive_limit);
                        sat_used       = drive_sat_next;
                        do_step        = drive_sat_next;
                    end
                end
                default:
                begin
                    do_step = 1'b0;
                end
            endcase

            // Start and stop commands.
            unique case (op)
                OP_START:
                begin
                    sample_cnt_next = '0;
                    mon_run_next    = 1'b1;
                end
                OP_STOP:
                begin
                    sample_cnt_next = '0;
                    mon_run_next    = 1'b0;
                    rise_run_next   = 1'b0;
                end
                default:
                begin
                end
            endcase

            // One rise-check step: escape, gather a sample or judge.
            if (do_step)
            begin
                if (in_band || !sat_used)
                begin
                    sample_cnt_next           = '0;
                    rise_run_next             = 1'b0;
                    result.rise_check_escaped = 1'b1;
                end
                else if (sample_cnt_reg < n_eff)
                begin
                    rise_run_next   = 1'b1;
                    recent_next[3]  = recent_reg[2];
                    recent_next[2]  = recent_reg[1];
                    recent_next[1]  = recent_reg[0];
                    recent_next[0]  = temp;
                    sample_cnt_next = sample_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    if (18'(rise_diff) <= rise_limit)
                    begin
                        result.no_rise = 1'b1;
                        mon_run_next   = 1'b0;
                    end
                    sample_cnt_next = '0;
                    rise_run_next   = 1'b0;
                end
            end

            // Temperature checks of a running monitor tick.
            if (op == OP_MONITOR && mon_run_reg)
            begin
                result.over_temperature = (temp >= max_temperature_reg);
                prev_temp_next  = temp;
                prev_valid_next = 1'b1;
                if (!slow_mode_reg)
                begin
                    if (temp_diff < 0)
                    begin
                        drop_cnt_next = drop_inc;
                        if (drop_mag >= 17'(drop_limit_reg))
                        begin
                            result.sharp_drop = 1'b1;
                            drop_cnt_next     = '0;
                        end
                        else if (drop_inc > LONG_DROP_COUNT)
                        begin
                            result.long_drop = 1'b1;
                            drop_cnt_next    = '0;
                        end
                    end
                    else
                    begin
                        drop_cnt_next = '0;
                    end
                end
            end
        end

        result.drive_at_limit = drive_sat_next;

        // Clearing slow mode restarts monitoring.
        if (cfg_accept && cfg_index == REG_SLOW_MODE && !cfg_data[0])
        begin
            sample_cnt_next = '0;
            mon_run_next    = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temperature_reg  <= 16'sd16000;
            drop_limit_reg       <= 15'd80;
            rise_threshold_reg   <= 16'sd16;
            check_samples_reg    <= 8'd10;
            band_low_offset_reg  <= -16'sd32;
            band_high_offset_reg <= 16'sd32;
            band_enable_reg      <= 1'b0;
            slow_mode_reg        <= 1'b0;
        end
        else if (cfg_accept)
        begin
            priority case (cfg_index)
                REG_MAX_TEMPERATURE:  max_temperature_reg  <= cfg_data;
                REG_DROP_LIMIT:       drop_limit_reg       <= cfg_data[14:0];
                REG_RISE_THRESHOLD:   rise_threshold_reg   <= cfg_data;
                REG_CHECK_SAMPLES:    check_samples_reg    <= cfg_data[7:0];
                REG_BAND_LOW_OFFSET:  band_low_offset_reg  <= cfg_data;
                REG_BAND_HIGH_OFFSET: band_high_offset_reg <= cfg_data;
                REG_BAND_ENABLE:      band_enable_reg      <= cfg_data[0];
                REG_SLOW_MODE:        slow_mode_reg        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Monitor state and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_temp_reg  <= '0;
            prev_valid_reg <= 1'b0;
            drop_cnt_reg   <= '0;
            drive_sat_reg  <= 1'b0;
            sample_cnt_reg <= '0;
            mon_run_reg    <= 1'b0;
            rise_run_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_temp_reg  <= prev_temp_next;
            prev_valid_reg <= prev_valid_next;
            drop_cnt_reg   <= drop_cnt_next;
            drive_sat_reg  <= drive_sat_next;
            sample_cnt_reg <= sample_cnt_next;
            mon_run_reg    <= mon_run_next;
            rise_run_reg   <= rise_run_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample store and result word; payload only, no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            recent_reg[i] <= recent_next[i];
        end
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the heater thermal safety monitor.
// It predicts every result word, compares it field by field and sweeps several register settings.
// It depends on htsm_pkg and on the heater_thermal_safety_monitor top level.
`timescale 1ns / 1ps

module testbench;
    import htsm_pkg::*;

    localparam int MAX_WINDOW  = 255;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 30;

    // One input word as the stimulus sees it.
    typedef struct {
        op_t                op;
        logic signed [15:0] temperature;
        logic signed [15:0] setpoint;
        logic signed [11:0] drive;
        logic signed [11:0] drive_limit;
    } heater_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [55:0]            s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted copy of the registers, at their reset values.
    logic signed [15:0] trip_level = 16'sd16000;
    logic [14:0]        drop_limit = 15'd80;
    logic signed [15:0] rise_threshold = 16'sd16;
    logic [7:0]         check_samples = 8'd10;
    logic signed [15:0] band_low = -16'sd32;
    logic signed [15:0] band_high = 16'sd32;
    logic               band_enable = 1'b0;
    logic               slow_mode = 1'b0;

    // Predicted copy of the monitor state.
    logic signed [15:0] last_temp = '0;
    logic               last_valid = 1'b0;
    logic [3:0]         drop_count = '0;
    logic               drive_sat = 1'b0;
    logic [7:0]         gathered = '0;
    logic signed [15:0] samples [4] = '{default: '0};
    logic               monitoring = 1'b0;
    logic               rise_active = 1'b0;

    result_t expected_flags [$];

    int  cycle_count = 0;
    int  mismatches = 0;
    int  results_checked = 0;
    int  words_sent = 0;
    int  settings_applied = 0;
    int  trips_ot = 0, trips_nr = 0, trips_sd = 0, trips_ld = 0, escapes = 0;
    int  idle_percent = 0;
    int  stall_left = 0;
    bit  steady_flow = 1'b0;

    heater_thermal_safety_monitor #(
        .MAX_CHECK_SAMPLES(MAX_WINDOW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // Cycle counter and watchdog.
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // One rise-check step of the predictor; it may escape, gather or judge.
    function automatic void advance_rise_check(input heater_word_t w, inout result_t r);
        int lo;
        int hi;
        int window;
        lo = int'(w.setpoint) + int'(band_low);
        hi = int'(w.setpoint) + int'(band_high);
        window = int'(check_samples);
        if (window < int'(MIN_CHECK_SAMPLES))
            window = int'(MIN_CHECK_SAMPLES);
        if (window > MAX_WINDOW)
            window = MAX_WINDOW;
        // Inside the band, or with the drive off its limit, the check is abandoned.
        if ((band_enable && int'(w.temperature) > lo && int'(w.temperature) < hi) || !drive_sat)
        begin
            gathered = '0;
            rise_active = 1'b0;
            r.rise_check_escaped = 1'b1;
            return;
        end
        rise_active = 1'b1;
        if (int'(gathered) < window)
        begin
            samples[3] = samples[2];
            samples[2] = samples[1];
            samples[1] = samples[0];
            samples[0] = w.temperature;
            gathered = gathered + 8'd1;
            return;
        end
        // Judgement: the rise over the last three steps against three thresholds.
        if (int'(samples[0]) - int'(samples[3]) <= 3 * int'(rise_threshold))
        begin
            r.no_rise = 1'b1;
            monitoring = 1'b0;
        end
        gathered = '0;
        rise_active = 1'b0;
    endfunction

    // Works out the result word for one accepted input word.
    function automatic result_t predict_flags(input heater_word_t w);
        result_t r;
        int      step_diff;
        r = '0;
        case (w.op)
            OP_START:
            begin
                gathered = '0;
                monitoring = 1'b1;
            end
            OP_STOP:
            begin
                monitoring = 1'b0;
                rise_active = 1'b0;
                gathered = '0;
            end
            OP_RISE:
            begin
                if (rise_active && !slow_mode)
                    advance_rise_check(w, r);
            end
            default:
            begin
                if (monitoring)
                begin
                    if (!slow_mode)
                    begin
                        drive_sat = (w.drive >= w.drive_limit);
                        if (drive_sat)
                            advance_rise_check(w, r);
                    end
                    r.over_temperature = (w.temperature >= trip_level);
                    step_diff = last_valid ? int'(w.temperature) - int'(last_temp) : 0;
                    last_temp = w.temperature;
                    last_valid = 1'b1;
                    if (!slow_mode)
                    begin
                        if (step_diff < 0)
                        begin
                            drop_count = drop_count + 4'd1;
                            if (-step_diff >= int'(drop_limit))
                            begin
                                r.sharp_drop = 1'b1;
                                drop_count = '0;
                            end
                            else if (drop_count > LONG_DROP_COUNT)
                            begin
                                r.long_drop = 1'b1;
                                drop_count = '0;
                            end
                        end
                        else
                            drop_count = '0;
                    end
                end
            end
        endcase
        r.drive_at_limit = drive_sat;
        return r;
    endfunction

    // Updates the predicted registers after a configuration write.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [15:0] value);
        case (index)
            REG_MAX_TEMPERATURE:  trip_level = value;
            REG_DROP_LIMIT:       drop_limit = value[14:0];
            REG_RISE_THRESHOLD:   rise_threshold = value;
            REG_CHECK_SAMPLES:    check_samples = value[7:0];
            REG_BAND_LOW_OFFSET:  band_low = value;
            REG_BAND_HIGH_OFFSET: band_high = value;
            REG_BAND_ENABLE:      band_enable = value[0];
            REG_SLOW_MODE:
            begin
                slow_mode = value[0];
                // Leaving slow mode restarts monitoring.
                if (!slow_mode)
                begin
                    gathered = '0;
                    monitoring = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic heater_word_t word_of(input op_t op, input int temp, input int sp,
                                             input int drv, input int lim);
        heater_word_t w;
        w.op = op;
        w.temperature = temp[15:0];
        w.setpoint = sp[15:0];
        w.drive = drv[11:0];
        w.drive_limit = lim[11:0];
        return w;
    endfunction

    // Picks a drive and a limit within range, at or off the limit as asked.
    function automatic void pick_drive(input bit saturate, output logic signed [11:0] drv,
                                       output logic signed [11:0] lim);
        int l;
        int d;
        l = int'($urandom_range(0, 1600)) - 500;
        if (!saturate && l == -500)
            l = -499;
        if (saturate)
            d = int'($urandom_range(l + 500, 1600)) - 500;
        else
            d = int'($urandom_range(0, l + 499)) - 500;
        lim = l[11:0];
        drv = d[11:0];
    endfunction

    // A word with op, temperature and setpoint drawn over their whole range.
    function automatic heater_word_t noise_word();
        heater_word_t w;
        w.op = op_t'($urandom_range(0, 3));
        w.temperature = 16'($urandom);
        w.setpoint = 16'($urandom);
        pick_drive($urandom_range(0, 1) == 1, w.drive, w.drive_limit);
        return w;
    endfunction

    // Mismatch report: one line each, counted always, printed up to a limit.
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at result %0d: %s is %0d, expected %0d",
                     results_checked, what, got, want);
    endtask

    task automatic check_bit(input string what, input logic got, input logic want);
        if (got !== want)
            report_mismatch(what, int'(got), int'(want));
    endtask

    // Result checker: every result word against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_flags.size() == 0)
                report_mismatch("unexpected result word", int'(m_tdata), 0);
            else
            begin
                want = expected_flags.pop_front();
                got = result_t'(m_tdata[5:0]);
                check_bit("over_temperature", got.over_temperature, want.over_temperature);
                check_bit("no_rise", got.no_rise, want.no_rise);
                check_bit("sharp_drop", got.sharp_drop, want.sharp_drop);
                check_bit("long_drop", got.long_drop, want.long_drop);
                check_bit("rise_check_escaped", got.rise_check_escaped,
                          want.rise_check_escaped);
                check_bit("drive_at_limit", got.drive_at_limit, want.drive_at_limit);
                if (m_tdata[7:6] !== 2'b00)
                    report_mismatch("padding", int'(m_tdata[7:6]), 0);
                trips_ot += want.over_temperature;
                trips_nr += want.no_rise;
                trips_sd += want.sharp_drop;
                trips_ld += want.long_drop;
                escapes += want.rise_check_escaped;
            end
            results_checked++;
        end
    end

    // Receiver: ready, with random stall bursts.
    always @(negedge clk)
    begin
        if (!rst_n || steady_flow)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 99) < idle_percent / 4)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Sends one word, maybe after an idle burst, and records its prediction.
    task automatic send_word(input heater_word_t w);
        int gap;
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < idle_percent)
            gap = $urandom_range(1, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.op;
        s_tdata <= {w.drive_limit, w.drive, w.setpoint, w.temperature};
        do @(posedge clk); while (!s_tready);
        expected_flags.insert(expected_flags.size(), predict_flags(w));
        words_sent++;
    endtask

    // Ends the stream and waits until every expected result has come.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        apply_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input int max_t, input int drop, input int thr, input int n,
                                  input int lo, input int hi, input bit band, input bit slow);
        write_register(REG_MAX_TEMPERATURE, max_t[15:0]);
        write_register(REG_DROP_LIMIT, {1'b0, drop[14:0]});
        write_register(REG_RISE_THRESHOLD, thr[15:0]);
        write_register(REG_CHECK_SAMPLES, {8'd0, n[7:0]});
        write_register(REG_BAND_LOW_OFFSET, lo[15:0]);
        write_register(REG_BAND_HIGH_OFFSET, hi[15:0]);
        write_register(REG_BAND_ENABLE, {15'd0, band});
        write_register(REG_SLOW_MODE, {15'd0, slow});
        settings_applied++;
    endtask

    // One heating episode: a start, then ticks following a temperature trend,
    // with occasional stops, restarts and noise words.
    task automatic run_heating_episode(input int words, input int sat_percent,
                                       input int stop_percent);
        heater_word_t w;
        int           temp;
        int           sp;
        int           slope;
        int           roll;
        case ($urandom_range(0, 2))
            0:       idle_percent = 0;
            1:       idle_percent = 15;
            default: idle_percent = 35;
        endcase
        case ($urandom_range(0, 7))
            0:       slope = -1;
            1:       slope = -3;
            2:       slope = 0;
            3:       slope = 8;
            4:       slope = 15;
            5:       slope = 16;
            6:       slope = 17;
            default: slope = 40;
        endcase
        temp = int'($urandom_range(0, 17000)) - 500;
        sp = int'(clamp16(temp + int'($urandom_range(0, 400)) - 60));
        if ($urandom_range(0, 9) == 0)
            sp = int'(clamp16(int'($urandom_range(0, 65535)) - 32768));
        send_word(word_of(OP_START, temp, sp, 0, 0));
        for (int k = 1; k < words; k++)
        begin
            temp = temp + slope;
            if ($urandom_range(0, 3) == 0)
                temp = temp + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 49) == 0)
                temp = temp - int'(drop_limit) + int'($urandom_range(0, 1));
            temp = int'(clamp16(temp));
            w = word_of(OP_MONITOR, temp, sp, 0, 0);
            pick_drive($urandom_range(0, 99) < sat_percent, w.drive, w.drive_limit);
            roll = $urandom_range(0, 99);
            if (stop_percent > 0 && roll < 4)
                w = noise_word();
            else if (!monitoring && roll < 40)
                w.op = OP_START;
            else if (stop_percent > 0 && roll < 4 + stop_percent)
                w.op = OP_STOP;
            else if (stop_percent > 0 && roll < 6 + stop_percent)
                w.op = OP_START;
            else if (roll < 32)
                w.op = OP_RISE;
            send_word(w);
        end
    endtask

    task automatic run_episodes(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total)
        begin
            len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       run_heating_episode(len, 60, 2);
                1:       run_heating_episode(len, 90, 2);
                default: run_heating_episode(len, 100, 1);
            endcase
            sent += len;
        end
    endtask

    // Ticks while stopped, over-temperature, sharp drop, escape and long drop.
    task automatic test_trip_flags();
        idle_percent = 20;
        send_word(word_of(OP_MONITOR, 0, 0, 1100, -500));
        send_word(word_of(OP_RISE, 0, 0, 1100, -500));
        send_word(word_of(OP_START, 0, 0, 0, 0));
        // First sample after start: no drop difference yet, drive at its limit.
        send_word(word_of(OP_MONITOR, 32767, -32768, 1100, -500));
        send_word(word_of(OP_MONITOR, -32768, 32767, -500, 1100));
        send_word(word_of(OP_RISE, 0, 0, -500, 1100));
        send_word(word_of(OP_MONITOR, 100, 0, 0, 1100));
        // Eleven successive drops of one.
        for (int k = 1; k <= 11; k++)
            send_word(word_of(OP_MONITOR, 100 - k, 0, 0, 1100));
        settle();
    endtask

    // A clamped window of four, a failed rise judged on a monitor tick, and a band escape.
    task automatic test_rise_judgement();
        write_settings(16000, 80, 16, 2, -32, 32, 1'b1, 1'b0);
        send_word(word_of(OP_START, 500, 0, 0, 0));
        send_word(word_of(OP_MONITOR, 500, 0, 1000, 1000));
        repeat (3) send_word(word_of(OP_RISE, 500, 0, 1000, 1000));
        send_word(word_of(OP_MONITOR, 16000, 0, 1000, 1000));
        send_word(word_of(OP_MONITOR, 0, 0, 1000, 1000));
        send_word(word_of(OP_START, 200, 200, 0, 0));
        send_word(word_of(OP_MONITOR, 200, 200, 1000, 1000));
        settle();
    endtask

    task automatic test_default_settings();
        write_settings(16000, 80, 16, 10, -32, 32, 1'b1, 1'b0);
        run_episodes(150);
        settle();
    endtask

    task automatic test_extreme_settings();
        write_settings(32767, 0, -32768, 4, -32768, 32767, 1'b0, 1'b0);
        run_episodes(120);
        settle();
        write_settings(-32768, 32767, 32767, 4, -100, 100, 1'b1, 1'b0);
        run_episodes(120);
        settle();
    endtask

    // Slow mode: only the over-temperature check stays active.
    task automatic test_slow_control();
        write_settings(int'($urandom_range(14000, 17000)), 40, 16, 6, -32, 32, 1'b1, 1'b1);
        send_word(word_of(OP_START, 0, 0, 0, 0));
        send_word(word_of(OP_MONITOR, 32767, 0, 1100, 1100));
        send_word(word_of(OP_RISE, 0, 0, 1100, 1100));
        run_episodes(100);
        settle();
    endtask

    // The widest window, with the drive held at its limit throughout.
    task automatic test_long_rise_window();
        write_settings(16000, 80, 5, 255, -32, 32, 1'b0, 1'b0);
        run_heating_episode(280, 100, 0);
        settle();
    endtask

    // Random settings, and the stream at full rate on both sides.
    task automatic test_random_settings();
        steady_flow = 1'b1;
        repeat (3)
        begin
            write_settings(int'($urandom_range(0, 65535)) - 32768,
                           $urandom_range(0, 32767),
                           int'($urandom_range(0, 100)) - 40,
                           $urandom_range(4, 20),
                           -int'($urandom_range(0, 200)),
                           $urandom_range(0, 200),
                           $urandom_range(0, 1) == 1, 1'b0);
            run_episodes(40);
            settle();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_trip_flags();
        test_rise_judgement();
        test_default_settings();
        test_extreme_settings();
        test_slow_control();
        test_long_rise_window();
        test_random_settings();
        $display("Sent %0d words and checked %0d results under %0d register settings.",
                 words_sent, results_checked, settings_applied);
        $display("Trips: over-temperature %0d, no rise %0d, sharp drop %0d, long drop %0d, %s %0d.",
                 trips_ot, trips_nr, trips_sd, trips_ld, "rise-check escapes", escapes);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
